>>> rtl/polar_to_cartesian_defines.svh
// ----------------------------------------------------------------------------
// polar_to_cartesian_defines
// assertion macros used by the polar_to_cartesian rtl
// ----------------------------------------------------------------------------
`ifndef POLAR_TO_CARTESIAN_DEFINES_SVH
`define POLAR_TO_CARTESIAN_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define P2C_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define P2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// constants shared by the polar to cartesian cordic pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package p2c_pkg;

    // pipeline defaults
    localparam int DEF_CORDIC_STAGES = 24;
    localparam int DEF_DATA_WIDTH    = 32;
    localparam int MAX_STAGES        = 32;

    // angle datapath width: 32-bit turn fraction plus fold headroom
    localparam int ZW = 34;

    // apb address width and register map
    localparam int APB_AW = 3;
    typedef enum logic {
        REG_ZERO_TOL = 1'b0
    } t_reg_idx;

    // cordic gain, 0.607252935 in Q0.30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // arctangent of 2^-i in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

endpackage

`default_nettype wire

>>> rtl/polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// polar_to_cartesian
// polar control point to Q16.16 x/y through a pipelined cordic rotation
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_radius, i_angle
//  out       output     o_out_valid / i_out_stall  o_x_coord, o_y_coord
//  cfg       apb        psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  one word accepted per cycle while o_in_stall is low; the pipeline stages are
//  gain multiply, prescale/fold, one cell per micro-rotation and the output register
//  the whole cell chain advances together while the output skid stage is empty
//  o_in_stall is the registered skid-full flag; a stalled output backs up
//  one word into the skid, after which the chain and the input hold
//  synchronous active-low reset clears all valid flags; zero_tolerance resets to 1
// ----------------------------------------------------------------------------
`default_nettype none

module polar_to_cartesian
    import p2c_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // apb configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_radius,
    input  wire logic [31:0]        i_angle,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_x_coord,
    output logic signed [31:0]      o_y_coord
);

    localparam int XW = DATA_WIDTH + 2;

    logic [30:0]          r_zero_tol;
    logic                 w_en;
    logic                 w_v [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_x [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_y [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_z [CORDIC_STAGES+1];
    t_reg_idx             w_idx;

    // configuration register
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol <= 31'd1;
        end else if (psel && penable && pwrite && (w_idx == REG_ZERO_TOL)) begin
            r_zero_tol <= pwdata[30:0];
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ZERO_TOL: prdata = {1'b0, r_zero_tol};
            default:      prdata = '0;
        endcase
    end

    assign o_in_stall = !w_en;

    // prescale and fold
    p2c_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_zero_tol (r_zero_tol),
        .i_valid    (i_in_valid),
        .i_radius   (i_radius),
        .i_angle    (i_angle),
        .o_valid    (w_v[0]),
        .o_x        (w_x[0]),
        .o_y        (w_y[0]),
        .o_z        (w_z[0])
    );

    // chain of micro-rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        p2c_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .STAGE      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    // scaling, saturation and output buffering
    p2c_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v[CORDIC_STAGES]),
        .i_x       (w_x[CORDIC_STAGES]),
        .i_y       (w_y[CORDIC_STAGES]),
        .o_en      (w_en),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_x_coord (o_x_coord),
        .o_y_coord (o_y_coord)
    );

    // residual angle of the last cell is not needed
    logic w_z_unused;
    assign w_z_unused = ^w_z[CORDIC_STAGES];

endmodule

`default_nettype wire

>>> rtl/p2c_front.sv
// ----------------------------------------------------------------------------
// p2c_front
// gain prescale, origin test and quadrant fold ahead of the cordic chain
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_front
    import p2c_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic [30:0]                    i_zero_tol,
    input  wire logic                           i_valid,
    input  wire logic signed [31:0]             i_radius,
    input  wire logic [31:0]                    i_angle,
    output logic                                o_valid,
    output logic signed [DATA_WIDTH+1:0]        o_x,
    output logic signed [DATA_WIDTH+1:0]        o_y,
    output logic signed [ZW-1:0]                o_z
);

    localparam int XW = DATA_WIDTH + 2;
    localparam int SH = 62 - DATA_WIDTH;
    localparam logic [61:0] ROUND = 62'(1) << (SH - 1);

    logic              r_v1;
    logic [60:0]       r_prod;
    logic [31:0]       r_ang;
    logic              w_zero;
    logic [61:0]       w_sum;
    logic [XW-1:0]     w_rs;
    logic signed [ZW-1:0] w_ze;
    logic              w_hi;
    logic              w_lo;
    logic signed [XW-1:0] n_x;
    logic signed [ZW-1:0] n_z;

    // origin test: negative radius or magnitude at or below tolerance
    assign w_zero = i_radius[31] || (i_radius[30:0] <= i_zero_tol);

    // stage one: gain multiply, forced to zero for the origin case
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_zero ? '0 : (61'(i_radius[30:0]) * 61'(GAIN_Q30));
            r_ang  <= i_angle;
        end
    end

    // rounded prescale and fold into the right half plane
    always_comb begin
        w_sum = {1'b0, r_prod} + ROUND;
        w_rs  = XW'(w_sum[SH +: DATA_WIDTH]);
        w_ze  = ZW'($signed(r_ang));
        w_hi  = !r_ang[31] && r_ang[30] && (|r_ang[29:0]);
        w_lo  = r_ang[31] && !r_ang[30];
        if (w_hi) begin
            n_x = -$signed(w_rs);
            n_z = w_ze - $signed(ZW'(34'h080000000));
        end else if (w_lo) begin
            n_x = -$signed(w_rs);
            n_z = w_ze + $signed(ZW'(34'h080000000));
        end else begin
            n_x = $signed(w_rs);
            n_z = w_ze;
        end
    end

    // stage two register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= '0;
            o_z <= n_z;
        end
    end

endmodule

`default_nettype wire

>>> rtl/p2c_cell.sv
// ----------------------------------------------------------------------------
// p2c_cell
// one cordic micro-rotation with its own pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_cell
    import p2c_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int STAGE      = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic signed [DATA_WIDTH+1:0]   i_x,
    input  wire logic signed [DATA_WIDTH+1:0]   i_y,
    input  wire logic signed [ZW-1:0]           i_z,
    output logic                                o_valid,
    output logic signed [DATA_WIDTH+1:0]        o_x,
    output logic signed [DATA_WIDTH+1:0]        o_y,
    output logic signed [ZW-1:0]                o_z
);

    localparam int XW = DATA_WIDTH + 2;
    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(ATAN_TURNS[STAGE]));

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    // rotate toward zero residual angle
    always_comb begin
        w_xs = i_x >>> STAGE;
        w_ys = i_y >>> STAGE;
        if (!i_z[ZW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end

endmodule

`default_nettype wire

>>> rtl/p2c_out.sv
// ----------------------------------------------------------------------------
// p2c_out
// output scaling and saturation, output register with skid stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "polar_to_cartesian_defines.svh"

module p2c_out
    import p2c_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic signed [DATA_WIDTH+1:0]   i_x,
    input  wire logic signed [DATA_WIDTH+1:0]   i_y,
    output logic                                o_en,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [31:0]                  o_x_coord,
    output logic signed [31:0]                  o_y_coord
);

    localparam int XW = DATA_WIDTH + 2;
    localparam int EW = XW + 17;
    localparam logic signed [EW-1:0] SAT_MAX = $signed(EW'(32'h7FFFFFFF));
    localparam logic signed [EW-1:0] SAT_MIN = -$signed(EW'(33'h080000000));

    logic signed [EW-1:0] w_xe;
    logic signed [EW-1:0] w_ye;
    logic signed [31:0]   w_xo;
    logic signed [31:0]   w_yo;
    logic                 r_skid_valid;
    logic signed [31:0]   r_skid_x;
    logic signed [31:0]   r_skid_y;
    logic                 w_push;
    logic                 w_take;

    // bring the datapath back to Q16.16
    generate
        if (DATA_WIDTH > 32) begin : g_round
            localparam int SH = DATA_WIDTH - 32;
            localparam logic signed [EW-1:0] HALF = $signed(EW'(1) << (SH - 1));
            assign w_xe = (EW'(i_x) + HALF) >>> SH;
            assign w_ye = (EW'(i_y) + HALF) >>> SH;
        end else if (DATA_WIDTH < 32) begin : g_scale
            localparam int SH = 32 - DATA_WIDTH;
            assign w_xe = EW'(i_x) <<< SH;
            assign w_ye = EW'(i_y) <<< SH;
        end else begin : g_keep
            assign w_xe = EW'(i_x);
            assign w_ye = EW'(i_y);
        end
    endgenerate

    // saturate to 32 bits
    always_comb begin
        if (w_xe > SAT_MAX) begin
            w_xo = SAT_MAX[31:0];
        end else if (w_xe < SAT_MIN) begin
            w_xo = SAT_MIN[31:0];
        end else begin
            w_xo = w_xe[31:0];
        end
        if (w_ye > SAT_MAX) begin
            w_yo = SAT_MAX[31:0];
        end else if (w_ye < SAT_MIN) begin
            w_yo = SAT_MIN[31:0];
        end else begin
            w_yo = w_ye[31:0];
        end
    end

    // pipeline moves while the skid stage is empty
    assign o_en   = !r_skid_valid;
    assign w_push = o_en && i_valid;
    assign w_take = o_valid && !i_stall;

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!o_valid || w_take) begin
            if (r_skid_valid) begin
                o_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                o_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!o_valid || w_take) begin
            if (r_skid_valid) begin
                o_x_coord <= r_skid_x;
                o_y_coord <= r_skid_y;
            end else if (w_push) begin
                o_x_coord <= w_xo;
                o_y_coord <= w_yo;
            end
        end else if (w_push) begin
            r_skid_x <= w_xo;
            r_skid_y <= w_yo;
        end
    end

    // skid holds a word only behind a waiting output word
    `P2C_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, o_valid, "skid without output")
    // a full skid drains as soon as the output word is taken
    `P2C_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_stall, !r_skid_valid && o_valid, "skid did not drain")
    // a word arriving at a stalled full output lands in the skid stage
    `P2C_ASSERT_NEXT(a_skid_catch, i_clk, i_rst_n, w_push && o_valid && i_stall, r_skid_valid, "word lost at output")

endmodule

`default_nettype wire

>>> dv/polar_to_cartesian_test.sv
// ----------------------------------------------------------------------------
// polar_to_cartesian_test
// self-checking bench for the polar to cartesian cordic pipeline
// ----------------------------------------------------------------------------
//  polar words stream in through the valid/stall input channel; every accepted
//  word is run through a bit-exact cordic predictor in the bench and the x/y
//  word that comes out is checked against the oldest prediction. directed
//  points cover the field extremes, folding around the quarter turns and the
//  zero tolerance boundary; the tolerance register is swept through several
//  settings over apb, and random points run with random gaps on both sides,
//  including a long output hold that backs the pipeline up into the input.
// ----------------------------------------------------------------------------

module polar_to_cartesian_test;
    import p2c_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = DEF_CORDIC_STAGES;
    localparam int DATA_W     = DEF_DATA_WIDTH;
    localparam int PIPE_LAT   = STAGES + 3;
    localparam int SPARE_IDX  = 1;
    localparam longint GAIN_K = 652032874;

    // arctangent of 2^-i in 2^-32 turns
    localparam longint TURN_ATAN [32] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C,
        'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
        'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005,
        'h00000002, 'h00000001, 'h00000000, 'h00000000
    };

    typedef struct {
        logic signed [31:0] radius;
        logic [31:0]        angle;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_point;

    // dut connections, every input known from time zero
    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [APB_AW-1:0]  paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_radius    = '0;
    logic [31:0]        i_angle     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_x_coord;
    logic signed [31:0] o_y_coord;

    // bench state
    logic [30:0] tolerance = 31'd1;
    t_point      expected_pts[$];
    int          mismatches    = 0;
    int          words_sent    = 0;
    int          points_seen   = 0;
    int          origin_points = 0;
    int          tol_settings  = 0;
    int          longest_hold  = 0;
    int          hold_req      = 0;
    bit          steady_tx     = 1'b0;
    bit          steady_rx     = 1'b0;

    polar_to_cartesian dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_radius    (i_radius),
        .i_angle     (i_angle),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_x_coord   (o_x_coord),
        .o_y_coord   (o_y_coord)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // scale from the datapath width back to Q16.16 and clamp to 32 bits
    function automatic logic signed [31:0] to_q16(longint v);
        longint o;
        int     sh;
        sh = DATA_W - 32;
        if (sh > 0) begin
            o = (v + (longint'(1) << (sh - 1))) >>> sh;
        end else if (sh < 0) begin
            o = v <<< (-sh);
        end else begin
            o = v;
        end
        if (o > longint'(32'sh7FFFFFFF)) o = 32'sh7FFFFFFF;
        if (o < -(longint'(1) << 31)) o = -(longint'(1) << 31);
        return o[31:0];
    endfunction

    // expected x/y for one polar word under the current tolerance
    function automatic t_point rotate_point(logic signed [31:0] rad, logic [31:0] ang);
        t_point p;
        longint r;
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint rs;
        int     sh;
        p.radius = rad;
        p.angle  = ang;
        p.x      = '0;
        p.y      = '0;
        r  = rad;
        z  = $signed(ang);
        sh = 62 - DATA_W;
        if (r <= longint'(tolerance)) return p;
        // gain compensation up front
        rs = (r * GAIN_K + (longint'(1) << (sh - 1))) >>> sh;
        // fold the left half plane onto the right one
        x = rs;
        y = 0;
        if (z > (longint'(1) << 30)) begin
            x = -rs;
            z = z - (longint'(1) << 31);
        end else if (z < -(longint'(1) << 30)) begin
            x = -rs;
            z = z + (longint'(1) << 31);
        end
        // micro-rotations
        for (int i = 0; i < STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - TURN_ATAN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + TURN_ATAN[i];
            end
        end
        p.x = to_q16(x);
        p.y = to_q16(y);
        return p;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // radius mix: full range, small, around the tolerance, negative, near max
    function automatic logic signed [31:0] pick_radius();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom >> $urandom_range(0, 31));
            1:       return 32'(longint'(tolerance) + $urandom_range(0, 4) - 2);
            2:       return -32'sd1 - 32'($urandom >> $urandom_range(1, 31));
            3:       return 32'h7FFFFFFF - 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // angle mix: mostly full range, some right around a multiple of a quarter turn
    function automatic logic [31:0] pick_angle();
        if ($urandom_range(0, 4) == 0)
            return 32'($urandom_range(0, 3) << 30) + 32'($urandom_range(0, 6)) - 32'd3;
        return $urandom;
    endfunction

    // apb write, setup then access
    task automatic apb_write(input int idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == int'(REG_ZERO_TOL)) tolerance = data[30:0];
    endtask

    // apb read of the tolerance, compared with the bench copy
    task automatic check_tolerance();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(4 * int'(REG_ZERO_TOL));
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {1'b0, tolerance}) begin
            $error("zero_tolerance: expected %0d, got %0d", tolerance, got);
            mismatches++;
        end
    endtask

    // offer one polar word, record its prediction once taken
    task automatic send_point(input logic signed [31:0] rad, input logic [31:0] ang);
        int gap;
        i_in_valid <= 1'b1;
        i_radius   <= rad;
        i_angle    <= ang;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_pts.push_back(rotate_point(rad, ang));
        words_sent++;
        gap = steady_tx ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and let every predicted word come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [31:0] value);
        wait_idle();
        apb_write(REG_ZERO_TOL, value);
        check_tolerance();
        tol_settings++;
    endtask

    // reset value of the tolerance and the boundary around it
    task automatic test_reset_state();
        check_tolerance();
        tol_settings++;
        send_point(32'sd1, 32'h00000000);
        send_point(32'sd2, 32'h00000000);
        send_point(32'sd0, 32'h20000000);
        send_point(-32'sd1, 32'h10000000);
    endtask

    // field extremes, folding and exact quarter turns
    task automatic test_directed_points();
        logic [31:0] turn_pts [10];
        turn_pts = '{32'h00000000, 32'h20000000, 32'h40000000, 32'h40000001,
                     32'h80000000, 32'hBFFFFFFF, 32'hC0000000, 32'hC0000001,
                     32'hFFFFFFFF, 32'h7FFFFFFF};
        foreach (turn_pts[i]) send_point(32'sh7FFFFFFF, turn_pts[i]);
        foreach (turn_pts[i]) send_point(32'sh00010000, turn_pts[i]);
        send_point(32'sh80000000, 32'h12345678);
        send_point(32'sh80000000, 32'hFFFFFFFF);
        send_point(32'sh55555555, 32'hAAAAAAAA);
        send_point(32'sh2AAAAAAA, 32'h55555555);
    endtask

    // tolerance extremes and the values just around each
    task automatic test_tolerance_edges();
        logic [31:0] tol_vals [4];
        logic [31:0] t;
        tol_vals = '{32'h00000000, 32'hFFFFFFFF, 32'h00010000, $urandom};
        foreach (tol_vals[k]) begin
            set_tolerance(tol_vals[k]);
            t = {1'b0, tolerance};
            send_point(t - 32'd1, pick_angle());
            send_point(t, pick_angle());
            send_point(t + 32'd1, pick_angle());
            send_point(pick_radius(), $urandom);
        end
        // a write off the register map leaves the tolerance alone
        wait_idle();
        apb_write(SPARE_IDX, 32'h00000005);
        check_tolerance();
        t = {1'b0, tolerance};
        send_point(t, 32'h30000000);
        send_point(t + 32'd1, 32'h30000000);
    endtask

    // random points across a range of tolerance settings
    task automatic test_random_points();
        logic [31:0] tol;
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 3))
                0:       tol = 32'd1;
                1:       tol = 32'($urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(0, 30));
                default: tol = 32'($urandom_range(0, 255));
            endcase
            set_tolerance(tol);
            steady_tx = (phase % 4 == 1);
            steady_rx = (phase % 4 == 2) || (phase % 4 == 1);
            repeat (110) send_point(pick_radius(), pick_angle());
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    // long output hold while the input keeps offering, then a full drain
    task automatic test_output_hold();
        wait_idle();
        hold_req  = 150;
        steady_tx = 1'b1;
        repeat (2) @(posedge i_clk);
        repeat (100) send_point(pick_radius(), pick_angle());
        steady_tx = 1'b0;
        wait_idle();
    endtask

    // output side stall pattern, with long holds on request
    initial begin : out_stall_gen
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                if (hold_req > longest_hold) longest_hold = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (!steady_rx && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge i_clk) begin : check_point
        t_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pts.size() == 0) begin
                $error("unexpected output word x_coord %0d y_coord %0d", o_x_coord, o_y_coord);
                mismatches++;
            end else begin
                want = expected_pts.pop_front();
                points_seen++;
                if (want.x == 0 && want.y == 0) origin_points++;
                if (o_x_coord !== want.x) begin
                    $error("x_coord: expected %0d, got %0d (radius %0d angle %h)",
                           want.x, o_x_coord, want.radius, want.angle);
                    mismatches++;
                end
                if (o_y_coord !== want.y) begin
                    $error("y_coord: expected %0d, got %0d (radius %0d angle %h)",
                           want.y, o_y_coord, want.radius, want.angle);
                    mismatches++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_points();
        test_tolerance_edges();
        test_random_points();
        test_output_hold();
        wait_idle();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        $display("%0d words sent, %0d points checked, %0d at the origin, %0d tolerance settings",
                 words_sent, points_seen, origin_points, tol_settings);
        $display("longest output hold %0d cycles, %0d mismatches", longest_hold, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/p2c_pkg.sv
rtl/p2c_front.sv
rtl/p2c_cell.sv
rtl/p2c_out.sv
rtl/polar_to_cartesian.sv
dv/polar_to_cartesian_test.sv
